/* design/tcc_pkg.sv */
// Package for the triangle circumcenter core: widths, payload types, pipeline depth.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package tcc_pkg;

    localparam int COORD_W = 32;                 // Q16.16 coordinate width
    localparam int DIFF_W  = COORD_W + 1;        // vertex differences
    localparam int SQ_W    = 2 * DIFF_W;         // products of two differences
    localparam int UU_W    = SQ_W;               // squared side lengths, unsigned
    localparam int HALF_W  = UU_W / 2;           // split point of a squared length
    localparam int PP_W    = DIFF_W + HALF_W + 1;// partial products
    localparam int PR_W    = 3 * COORD_W + 4;    // full numerator products
    localparam int N_W     = PR_W + 1;           // numerators
    localparam int D_W     = 2 * COORD_W + 4;    // denominator 2*cross
    localparam int DV_W    = D_W + 1;            // divisor 2*|d|
    localparam int NUM_W   = N_W + 1;            // dividend 2*|n| + |d|
    localparam int QB      = COORD_W + 2;        // quotient bits kept
    localparam int RW      = 3 * COORD_W + 7;    // divider remainder width
    localparam int SUM_W   = COORD_W + 4;        // center before saturation
    localparam int NUMER_STAGES = 7;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_a_x;
        logic signed [COORD_W-1:0] point_a_y;
        logic signed [COORD_W-1:0] point_b_x;
        logic signed [COORD_W-1:0] point_b_y;
        logic signed [COORD_W-1:0] point_c_x;
        logic signed [COORD_W-1:0] point_c_y;
    } t_pts;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic                      degenerate;
    } t_ctr;

    // Work handed from the numerator pipeline to the divider.
    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic        [NUM_W-1:0]   num_x;
        logic        [NUM_W-1:0]   num_y;
        logic        [DV_W-1:0]    dv;
        logic                      neg_x;
        logic                      neg_y;
        logic                      zero;
    } t_job;

    // Rounded quotient magnitudes handed from the divider to the output stage.
    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic        [QB-1:0]      q_x;
        logic        [QB-1:0]      q_y;
        logic                      ovf_x;
        logic                      ovf_y;
        logic                      neg_x;
        logic                      neg_y;
        logic                      zero;
    } t_quo;

endpackage

/* design/tcc_pts_if.sv */
// Input channel of the circumcenter core: valid, ready and the three vertices.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

interface tcc_pts_if import tcc_pkg::*; ();
    logic valid;
    logic ready;
    t_pts data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/tcc_ctr_if.sv */
// Output channel of the circumcenter core: valid, ready, center and flag.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

interface tcc_ctr_if import tcc_pkg::*; ();
    logic valid;
    logic ready;
    t_ctr data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/tcc_numer.sv */
// Numerator pipeline: differences, squares, cross product and the two dividends.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_numer import tcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    output logic o_rdy,
    input  t_pts i_pts,
    output logic o_vld,
    input  logic i_rdy,
    output t_job o_job
);

    logic [NUMER_STAGES-1:0] r_vld;
    logic [NUMER_STAGES-1:0] en;

    // A stage takes new data when it is empty or its content moves on.
    assign en[NUMER_STAGES-1] = !r_vld[NUMER_STAGES-1] || i_rdy;
    for (genvar s = 0; s < NUMER_STAGES - 1; s++) begin : g_en
        assign en[s] = !r_vld[s] || en[s+1];
    end

    assign o_rdy = en[0];
    assign o_vld = r_vld[NUMER_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int s = 1; s < NUMER_STAGES; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Stage 0: edge vectors from A.
    logic signed [DIFF_W-1:0]  r0_ux, r0_uy, r0_vx, r0_vy;
    logic signed [COORD_W-1:0] r0_ax, r0_ay;
    // Stage 1: products of differences.
    logic signed [SQ_W-1:0]    r1_uxux, r1_uyuy, r1_vxvx, r1_vyvy, r1_uxvy, r1_uyvx;
    logic signed [DIFF_W-1:0]  r1_ux, r1_uy, r1_vx, r1_vy;
    logic signed [COORD_W-1:0] r1_ax, r1_ay;
    // Stage 2: squared lengths and denominator.
    logic        [UU_W-1:0]    r2_uu, r2_vv;
    logic signed [D_W-1:0]     r2_d;
    logic signed [DIFF_W-1:0]  r2_ux, r2_uy, r2_vx, r2_vy;
    logic signed [COORD_W-1:0] r2_ax, r2_ay;
    // Stage 3: halves of the numerator products.
    logic signed [PP_W-1:0]    r3_a_lo, r3_a_hi, r3_b_lo, r3_b_hi;
    logic signed [PP_W-1:0]    r3_c_lo, r3_c_hi, r3_e_lo, r3_e_hi;
    logic signed [D_W-1:0]     r3_d;
    logic signed [COORD_W-1:0] r3_ax, r3_ay;
    // Stage 4: full products.
    logic signed [PR_W-1:0]    r4_a, r4_b, r4_c, r4_e;
    logic signed [D_W-1:0]     r4_d;
    logic signed [COORD_W-1:0] r4_ax, r4_ay;
    // Stage 5: numerators.
    logic signed [N_W-1:0]     r5_nx, r5_ny;
    logic signed [D_W-1:0]     r5_d;
    logic signed [COORD_W-1:0] r5_ax, r5_ay;
    // Stage 6: dividends for round-to-nearest division.
    t_job                      r6_job;

    logic [N_W-1:0] n_mag_x, n_mag_y;
    logic [D_W-1:0] n_mag_d;

    always_comb begin
        n_mag_x = r5_nx[N_W-1] ? N_W'(-r5_nx) : N_W'(r5_nx);
        n_mag_y = r5_ny[N_W-1] ? N_W'(-r5_ny) : N_W'(r5_ny);
        n_mag_d = r5_d[D_W-1] ? D_W'(-r5_d) : D_W'(r5_d);
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_ux <= DIFF_W'(i_pts.point_b_x) - DIFF_W'(i_pts.point_a_x);
            r0_uy <= DIFF_W'(i_pts.point_b_y) - DIFF_W'(i_pts.point_a_y);
            r0_vx <= DIFF_W'(i_pts.point_c_x) - DIFF_W'(i_pts.point_a_x);
            r0_vy <= DIFF_W'(i_pts.point_c_y) - DIFF_W'(i_pts.point_a_y);
            r0_ax <= i_pts.point_a_x;
            r0_ay <= i_pts.point_a_y;
        end
        if (en[1]) begin
            r1_uxux <= r0_ux * r0_ux;
            r1_uyuy <= r0_uy * r0_uy;
            r1_vxvx <= r0_vx * r0_vx;
            r1_vyvy <= r0_vy * r0_vy;
            r1_uxvy <= r0_ux * r0_vy;
            r1_uyvx <= r0_uy * r0_vx;
            r1_ux   <= r0_ux;
            r1_uy   <= r0_uy;
            r1_vx   <= r0_vx;
            r1_vy   <= r0_vy;
            r1_ax   <= r0_ax;
            r1_ay   <= r0_ay;
        end
        if (en[2]) begin
            r2_uu <= $unsigned(r1_uxux) + $unsigned(r1_uyuy);
            r2_vv <= $unsigned(r1_vxvx) + $unsigned(r1_vyvy);
            r2_d  <= (D_W'(r1_uxvy) - D_W'(r1_uyvx)) <<< 1;
            r2_ux <= r1_ux;
            r2_uy <= r1_uy;
            r2_vx <= r1_vx;
            r2_vy <= r1_vy;
            r2_ax <= r1_ax;
            r2_ay <= r1_ay;
        end
        if (en[3]) begin
            r3_a_lo <= r2_vy * $signed({1'b0, r2_uu[HALF_W-1:0]});
            r3_a_hi <= r2_vy * $signed({1'b0, r2_uu[UU_W-1:HALF_W]});
            r3_b_lo <= r2_uy * $signed({1'b0, r2_vv[HALF_W-1:0]});
            r3_b_hi <= r2_uy * $signed({1'b0, r2_vv[UU_W-1:HALF_W]});
            r3_c_lo <= r2_ux * $signed({1'b0, r2_vv[HALF_W-1:0]});
            r3_c_hi <= r2_ux * $signed({1'b0, r2_vv[UU_W-1:HALF_W]});
            r3_e_lo <= r2_vx * $signed({1'b0, r2_uu[HALF_W-1:0]});
            r3_e_hi <= r2_vx * $signed({1'b0, r2_uu[UU_W-1:HALF_W]});
            r3_d    <= r2_d;
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
        end
        if (en[4]) begin
            r4_a  <= (PR_W'(r3_a_hi) <<< HALF_W) + PR_W'(r3_a_lo);
            r4_b  <= (PR_W'(r3_b_hi) <<< HALF_W) + PR_W'(r3_b_lo);
            r4_c  <= (PR_W'(r3_c_hi) <<< HALF_W) + PR_W'(r3_c_lo);
            r4_e  <= (PR_W'(r3_e_hi) <<< HALF_W) + PR_W'(r3_e_lo);
            r4_d  <= r3_d;
            r4_ax <= r3_ax;
            r4_ay <= r3_ay;
        end
        if (en[5]) begin
            r5_nx <= N_W'(r4_a) - N_W'(r4_b);
            r5_ny <= N_W'(r4_c) - N_W'(r4_e);
            r5_d  <= r4_d;
            r5_ax <= r4_ax;
            r5_ay <= r4_ay;
        end
        if (en[6]) begin
            r6_job.num_x <= {n_mag_x, 1'b0} + NUM_W'(n_mag_d);
            r6_job.num_y <= {n_mag_y, 1'b0} + NUM_W'(n_mag_d);
            r6_job.dv    <= {n_mag_d, 1'b0};
            r6_job.neg_x <= r5_nx[N_W-1] ^ r5_d[D_W-1];
            r6_job.neg_y <= r5_ny[N_W-1] ^ r5_d[D_W-1];
            r6_job.zero  <= (r5_d == '0);
            r6_job.ax    <= r5_ax;
            r6_job.ay    <= r5_ay;
        end
    end

    assign o_job = r6_job;

endmodule

/* design/tcc_div.sv */
// Pipelined restoring divider, one quotient bit per stage, x and y lanes side by side.
// Depends on tcc_pkg.
`timescale 1ns / 1ps

module tcc_div import tcc_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    output logic o_rdy,
    input  t_job i_job,
    output logic o_vld,
    input  logic i_rdy,
    output t_quo o_quo
);

    localparam int NS = QB + 1;

    logic [NS-1:0]             r_vld;
    logic [NS-1:0]             en;
    logic [RW-1:0]             r_rem_x [NS];
    logic [RW-1:0]             r_rem_y [NS];
    logic [QB-1:0]             r_q_x   [NS];
    logic [QB-1:0]             r_q_y   [NS];
    logic [DV_W-1:0]           r_dv    [NS];
    logic signed [COORD_W-1:0] r_ax    [NS];
    logic signed [COORD_W-1:0] r_ay    [NS];
    logic [NS-1:0]             r_ovf_x, r_ovf_y, r_neg_x, r_neg_y, r_zero;
    logic [RW-1:0]             step_sh [NS];
    logic [NS-1:0]             take_x, take_y;

    assign en[NS-1] = !r_vld[NS-1] || i_rdy;
    for (genvar s = 0; s < NS - 1; s++) begin : g_en
        assign en[s] = !r_vld[s] || en[s+1];
    end

    assign o_rdy = en[0];
    assign o_vld = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_vld;
            end
            for (int s = 1; s < NS; s++) begin
                if (en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Stage k compares the remainder with the divisor shifted to quotient bit QB - k.
    always_comb begin
        step_sh[0] = '0;
        take_x[0]  = 1'b0;
        take_y[0]  = 1'b0;
        for (int k = 1; k < NS; k++) begin
            step_sh[k] = RW'(r_dv[k-1]) << (QB - k);
            take_x[k]  = r_rem_x[k-1] >= step_sh[k];
            take_y[k]  = r_rem_y[k-1] >= step_sh[k];
        end
    end

    // First stage flags quotients that do not fit in QB bits; they saturate later.
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rem_x[0] <= RW'(i_job.num_x);
            r_rem_y[0] <= RW'(i_job.num_y);
            r_q_x[0]   <= '0;
            r_q_y[0]   <= '0;
            r_ovf_x[0] <= RW'(i_job.num_x) >= (RW'(i_job.dv) << QB);
            r_ovf_y[0] <= RW'(i_job.num_y) >= (RW'(i_job.dv) << QB);
            r_dv[0]    <= i_job.dv;
            r_neg_x[0] <= i_job.neg_x;
            r_neg_y[0] <= i_job.neg_y;
            r_zero[0]  <= i_job.zero;
            r_ax[0]    <= i_job.ax;
            r_ay[0]    <= i_job.ay;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                r_rem_x[k] <= take_x[k] ? r_rem_x[k-1] - step_sh[k] : r_rem_x[k-1];
                r_rem_y[k] <= take_y[k] ? r_rem_y[k-1] - step_sh[k] : r_rem_y[k-1];
                r_q_x[k]   <= r_q_x[k-1] | (QB'(take_x[k]) << (QB - k));
                r_q_y[k]   <= r_q_y[k-1] | (QB'(take_y[k]) << (QB - k));
                r_ovf_x[k] <= r_ovf_x[k-1];
                r_ovf_y[k] <= r_ovf_y[k-1];
                r_dv[k]    <= r_dv[k-1];
                r_neg_x[k] <= r_neg_x[k-1];
                r_neg_y[k] <= r_neg_y[k-1];
                r_zero[k]  <= r_zero[k-1];
                r_ax[k]    <= r_ax[k-1];
                r_ay[k]    <= r_ay[k-1];
            end
        end
    end

    always_comb begin
        o_quo.ax    = r_ax[NS-1];
        o_quo.ay    = r_ay[NS-1];
        o_quo.q_x   = r_q_x[NS-1];
        o_quo.q_y   = r_q_y[NS-1];
        o_quo.ovf_x = r_ovf_x[NS-1];
        o_quo.ovf_y = r_ovf_y[NS-1];
        o_quo.neg_x = r_neg_x[NS-1];
        o_quo.neg_y = r_neg_y[NS-1];
        o_quo.zero  = r_zero[NS-1];
    end

endmodule

/* design/triangle_circumcenter_core.sv */
// Top level of the triangle circumcenter core: numerator pipeline, divider, output stage.
// Depends on tcc_pkg, tcc_pts_if, tcc_ctr_if, tcc_numer and tcc_div.
`timescale 1ns / 1ps

// The core takes the three vertices of a triangle in signed Q16.16 and returns the
// circumcenter in the same format, with a degenerate flag that is set when the
// vertices are collinear or two coincide (the center then reads as zero) or when a
// coordinate of the center falls outside the Q16.16 range and saturates. The
// computation is exact: the center is A plus the rational offset
// ((vy*|u|^2 - uy*|v|^2) / D, (ux*|v|^2 - vx*|u|^2) / D) with u = B - A,
// v = C - A and D = 2*(ux*vy - uy*vx), rounded to nearest with ties away from
// zero. The core is a fully pipelined datapath that accepts one transfer per
// cycle unless back pressure stalls it, and takes each input through these stages:
// seven stages form the products and dividends, one stage screens quotients too
// large for the output, 34 stages each resolve one quotient bit of a restoring
// divider (the divider makes up most of the depth), and one output register
// adds A and saturates. Every stage holds its item under back pressure and empty
// stages fill up, so a stalled output never drops or repeats a result. The core
// keeps no state between triangles.

module triangle_circumcenter_core import tcc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    tcc_pts_if.sink          i_pts,
    tcc_ctr_if.source        o_ctr
);

    logic numer_vld, numer_rdy;
    t_job numer_job;
    logic div_vld, div_rdy;
    t_quo div_quo;

    logic r_out_vld;
    t_ctr r_out;
    logic out_en;

    tcc_numer u_numer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_pts.valid),
        .o_rdy   (i_pts.ready),
        .i_pts   (i_pts.data),
        .o_vld   (numer_vld),
        .i_rdy   (numer_rdy),
        .o_job   (numer_job)
    );

    tcc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (numer_vld),
        .o_rdy   (numer_rdy),
        .i_job   (numer_job),
        .o_vld   (div_vld),
        .i_rdy   (div_rdy),
        .o_quo   (div_quo)
    );

    // Output register: it loads whenever it is empty or its result is taken.
    assign out_en  = !r_out_vld || o_ctr.ready;
    assign div_rdy = out_en;

    localparam logic signed [SUM_W-1:0] MAX_S = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] MIN_S = -MAX_S - SUM_W'(1);

    logic signed [QB:0]        q_sx, q_sy;
    logic signed [SUM_W-1:0]   sum_x, sum_y;
    logic signed [COORD_W-1:0] n_cx, n_cy;
    logic                      n_flag_x, n_flag_y;

    always_comb begin
        q_sx = div_quo.neg_x ? -$signed({1'b0, div_quo.q_x}) : $signed({1'b0, div_quo.q_x});
        q_sy = div_quo.neg_y ? -$signed({1'b0, div_quo.q_y}) : $signed({1'b0, div_quo.q_y});
        sum_x = SUM_W'(div_quo.ax) + SUM_W'(q_sx);
        sum_y = SUM_W'(div_quo.ay) + SUM_W'(q_sy);

        // A quotient past QB bits lies far outside the range, so its sign decides.
        if (div_quo.ovf_x) begin
            n_flag_x = 1'b1;
            n_cx     = div_quo.neg_x ? COORD_W'(MIN_S) : COORD_W'(MAX_S);
        end else if (sum_x > MAX_S) begin
            n_flag_x = 1'b1;
            n_cx     = COORD_W'(MAX_S);
        end else if (sum_x < MIN_S) begin
            n_flag_x = 1'b1;
            n_cx     = COORD_W'(MIN_S);
        end else begin
            n_flag_x = 1'b0;
            n_cx     = COORD_W'(sum_x);
        end

        if (div_quo.ovf_y) begin
            n_flag_y = 1'b1;
            n_cy     = div_quo.neg_y ? COORD_W'(MIN_S) : COORD_W'(MAX_S);
        end else if (sum_y > MAX_S) begin
            n_flag_y = 1'b1;
            n_cy     = COORD_W'(MAX_S);
        end else if (sum_y < MIN_S) begin
            n_flag_y = 1'b1;
            n_cy     = COORD_W'(MIN_S);
        end else begin
            n_flag_y = 1'b0;
            n_cy     = COORD_W'(sum_y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_en) begin
            r_out_vld <= div_vld;
        end
    end

    // A degenerate triangle gives a zero center with the flag set.
    always_ff @(posedge i_clk) begin
        if (out_en) begin
            if (div_quo.zero) begin
                r_out.center_x   <= '0;
                r_out.center_y   <= '0;
                r_out.degenerate <= 1'b1;
            end else begin
                r_out.center_x   <= n_cx;
                r_out.center_y   <= n_cy;
                r_out.degenerate <= n_flag_x | n_flag_y;
            end
        end
    end

    assign o_ctr.valid = r_out_vld;
    assign o_ctr.data  = r_out;

endmodule

/* test/tcc_checker.sv */
// Checker for the triangle circumcenter core: watches both channels, predicts centers, compares.
// Depends on tcc_pkg, tcc_pts_if and tcc_ctr_if.
`timescale 1ns / 1ps

module tcc_checker import tcc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcc_pts_if        i_pts,
    tcc_ctr_if        i_ctr,
    output int        o_errors,
    output int        o_pending
);

    t_ctr center_queue[$];
    int   error_count = 0;

    assign o_errors = error_count;

    // n / d rounded to nearest, ties away from zero; d is nonzero.
    function automatic logic signed [255:0] round_quotient(logic signed [255:0] n,
                                                           logic signed [255:0] d);
        logic signed [255:0] an;
        logic signed [255:0] ad;
        logic signed [255:0] q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q  = (2 * an + ad) / (2 * ad);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(logic signed [255:0] v,
                                                              ref logic flag);
        logic signed [255:0] hi;
        logic signed [255:0] lo;
        hi = (256'sd1 <<< (COORD_W - 1)) - 1;
        lo = -(256'sd1 <<< (COORD_W - 1));
        if (v > hi) begin
            flag = 1'b1;
            return hi[COORD_W-1:0];
        end
        if (v < lo) begin
            flag = 1'b1;
            return lo[COORD_W-1:0];
        end
        return v[COORD_W-1:0];
    endfunction

    function automatic t_ctr predict_center(t_pts p);
        logic signed [255:0] ax, ay, ux, uy, vx, vy, uu, vv, d, nx, ny;
        logic                flag;
        t_ctr                r;
        ax = p.point_a_x;
        ay = p.point_a_y;
        ux = 256'(p.point_b_x) - ax;
        uy = 256'(p.point_b_y) - ay;
        vx = 256'(p.point_c_x) - ax;
        vy = 256'(p.point_c_y) - ay;
        uu = ux * ux + uy * uy;
        vv = vx * vx + vy * vy;
        d  = 2 * (ux * vy - uy * vx);
        flag = 1'b0;
        if (d == 0) begin
            r.center_x   = '0;
            r.center_y   = '0;
            r.degenerate = 1'b1;
            return r;
        end
        nx = vy * uu - uy * vv;
        ny = ux * vv - vx * uu;
        r.center_x   = clamp_coord(ax + round_quotient(nx, d), flag);
        r.center_y   = clamp_coord(ay + round_quotient(ny, d), flag);
        r.degenerate = flag;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [COORD_W-1:0] got,
                                   logic [COORD_W-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_ctr want;
        if (!i_rst_n) begin
            error_count = 0;
        end else begin
            if (i_pts.valid && i_pts.ready)
                center_queue.push_back(predict_center(i_pts.data));
            if (i_ctr.valid && i_ctr.ready) begin
                if (center_queue.size() == 0) begin
                    report_mismatch("unexpected transfer", i_ctr.data.center_x, '0);
                end else begin
                    want = center_queue.pop_front();
                    if (i_ctr.data.center_x !== want.center_x)
                        report_mismatch("center_x", i_ctr.data.center_x, want.center_x);
                    if (i_ctr.data.center_y !== want.center_y)
                        report_mismatch("center_y", i_ctr.data.center_y, want.center_y);
                    if (i_ctr.data.degenerate !== want.degenerate)
                        report_mismatch("degenerate", i_ctr.data.degenerate,
                                        want.degenerate);
                end
            end
        end
        o_pending = center_queue.size();
    end

endmodule

/* test/triangle_circumcenter_core_test.sv */
// Top of the circumcenter core testbench: clock, reset, triangle stimulus, verdict.
// Depends on tcc_pkg, the channel interfaces, tcc_checker and the core.
`timescale 1ns / 1ps

module triangle_circumcenter_core_test import tcc_pkg::*; ();

    localparam int LATENCY     = 43;
    localparam int MAX_CYCLE   = 400000;
    localparam int HOLD_CYCLES = 300;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   error_count;
    int   pending_count;
    int   cycle_count = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_req = 1'b0;
    int   hold_count = 0;

    tcc_pts_if pts_ch ();
    tcc_ctr_if ctr_ch ();

    triangle_circumcenter_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pts   (pts_ch.sink),
        .o_ctr   (ctr_ch.source)
    );

    tcc_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pts     (pts_ch),
        .i_ctr     (ctr_ch),
        .o_errors  (error_count),
        .o_pending (pending_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: a long hold-off once it is requested, otherwise random stalls.
    always @(posedge i_clk) begin
        if (hold_req && hold_count < HOLD_CYCLES) begin
            hold_count   <= hold_count + 1;
            ctr_ch.ready <= 1'b0;
        end else begin
            ctr_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [COORD_W-1:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom();
            1: return 32'($signed(16'($urandom()))) <<< 16;
            2: return 32'($signed(12'($urandom())));
            3: return 32'($signed(24'($urandom())));
            4: return $urandom_range(1) ? 32'sh7fff_ffff - $urandom_range(3)
                                        : 32'sh8000_0000 + $urandom_range(3);
            default: return 32'($signed(20'($urandom()))) <<< $urandom_range(12);
        endcase
    endfunction

    function automatic t_pts rand_triangle();
        t_pts t;
        int   kind;
        t.point_a_x = rand_coord();
        t.point_a_y = rand_coord();
        t.point_b_x = rand_coord();
        t.point_b_y = rand_coord();
        t.point_c_x = rand_coord();
        t.point_c_y = rand_coord();
        kind = $urandom_range(9);
        // Coincident vertices and collinear points reach the degenerate path.
        if (kind == 0) begin
            t.point_c_x = t.point_a_x;
            t.point_c_y = t.point_a_y;
        end else if (kind == 1) begin
            t.point_b_x = t.point_a_x + 3 * 32'($signed(14'($urandom())));
            t.point_b_y = t.point_a_y + 5 * 32'($signed(14'($urandom())));
            t.point_c_x = t.point_a_x + 2 * (t.point_b_x - t.point_a_x);
            t.point_c_y = t.point_a_y + 2 * (t.point_b_y - t.point_a_y);
        end else if (kind == 2) begin
            // Nearly collinear: a huge center that saturates, or collinear when the offset is zero.
            t.point_b_x = t.point_a_x + 32'sd65536;
            t.point_b_y = t.point_a_y;
            t.point_c_x = t.point_a_x + 32'sd131072;
            t.point_c_y = t.point_a_y + $urandom_range(3);
        end
        return t;
    endfunction

    // Offer one triangle and hold it until the core takes it.
    task automatic send_triangle(t_pts t);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            pts_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        pts_ch.valid <= 1'b1;
        pts_ch.data  <= t;
        @(posedge i_clk);
        while (!pts_ch.ready) @(posedge i_clk);
    endtask

    task automatic make_triangle(int ax, int ay, int bx, int by, int cx, int cy);
        t_pts t;
        t = '{ax, ay, bx, by, cx, cy};
        send_triangle(t);
    endtask

    task automatic drain_results();
        pts_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
    endtask

    initial begin
        t_pts t;
        pts_ch.valid = 1'b0;
        pts_ch.data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: right triangles, coincident and collinear vertices, extremes.
        make_triangle(0, 0, 32'h0002_0000, 0, 0, 32'h0002_0000);
        make_triangle(0, 0, 1, 0, 0, 1);
        make_triangle(0, 0, 1, 0, 1, 1);
        make_triangle(5, 5, 5, 5, 9, 1);
        make_triangle(7, 7, 7, 7, 7, 7);
        make_triangle(0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0002_0000);
        make_triangle(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                      32'h7fff_ffff, 32'h8000_0000);
        make_triangle(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                      32'h8000_0000, 32'h7fff_ffff);
        make_triangle(32'hffff_ffff, 32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa,
                      32'haaaa_aaaa, 32'h5555_5555);
        make_triangle(0, 0, 32'h0001_0000, 0, 32'h0002_0000, 1);
        make_triangle(0, 0, 32'h7fff_ffff, 0, 32'h8000_0000, 1);
        make_triangle(0, 0, 2, 0, 1, 1);
        make_triangle(0, 0, 3, 0, 0, 1);
        make_triangle(32'hffff_0000, 32'h0001_0000, 32'h0001_0000, 32'hffff_0000,
                      32'h0003_0000, 32'h0005_0000);
        drain_results();

        // Random phases with different idling mixes.
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                3: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (phase == 4) hold_req = 1'b1;  // long back pressure fills the pipe
            for (int k = 0; k < 108; k++) begin
                t = rand_triangle();
                send_triangle(t);
            end
            drain_results();
        end

        repeat (LATENCY + 10) @(posedge i_clk);
        if (error_count == 0 && pending_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
design/tcc_pkg.sv
design/tcc_pts_if.sv
design/tcc_ctr_if.sv
design/tcc_numer.sv
design/tcc_div.sv
design/triangle_circumcenter_core.sv
test/tcc_checker.sv
test/triangle_circumcenter_core_test.sv
